### rtl/source_token_scanner_defines.svh
// Assertion helpers shared by the scanner RTL.
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    // Token kinds.
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_PLUS    = 5'd1;
    localparam logic [4:0] KIND_SEMI    = 5'd2;
    localparam logic [4:0] KIND_LBRACE  = 5'd3;
    localparam logic [4:0] KIND_RBRACE  = 5'd4;
    localparam logic [4:0] KIND_LPAREN  = 5'd5;
    localparam logic [4:0] KIND_RPAREN  = 5'd6;
    localparam logic [4:0] KIND_ASSIGN  = 5'd7;
    localparam logic [4:0] KIND_STRING  = 5'd8;
    localparam logic [4:0] KIND_INT     = 5'd9;
    localparam logic [4:0] KIND_IDENT   = 5'd10;
    localparam logic [4:0] KIND_ELSE    = 5'd11;
    localparam logic [4:0] KIND_INVALID = 5'd16;

    // Diagnostics.
    localparam logic [1:0] DIAG_NONE     = 2'd0;
    localparam logic [1:0] DIAG_BAD_CHAR = 2'd1;
    localparam logic [1:0] DIAG_OVERFLOW = 2'd2;
    localparam logic [1:0] DIAG_UNENDED  = 2'd3;

    // Source bytes with a meaning of their own.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword table, entry k gives kind KIND_ELSE + k. Text is right-justified,
    // first character in the highest used byte.
    localparam int KW_COUNT   = 5;
    localparam int KW_MAX_TXT = 5;
    localparam logic [KW_COUNT-1:0][8*KW_MAX_TXT-1:0] KW_TEXT = {
        40'("trim"), 40'("print"), 40'("my"), 40'("if"), 40'("else")
    };
    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = {3'd4, 3'd5, 3'd2, 3'd2, 3'd4};

    // Result queue depth; a byte can produce two results.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_STR   = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] start_pos;
        logic [31:0] end_pos;
        logic [63:0] value;
        logic [1:0]  diag;
        logic [7:0]  bad;
        logic        last;
    } t_token;

    typedef struct packed {
        logic   valid0;
        logic   valid1;
        t_token tok0;
        t_token tok1;
    } t_push;

endpackage

`default_nettype wire

### rtl/sts_core.sv
`default_nettype none
`include "source_token_scanner_defines.svh"

module sts_core #(
    parameter int POS_WIDTH       = 32,
    parameter int KEYWORD_MAX_LEN = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_char,
    output sts_pkg::t_push     o_push
);
    import sts_pkg::*;

    localparam int LENW = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int IDXW = $clog2(KEYWORD_MAX_LEN);

    t_scan_mode             r_mode, n_mode;
    logic [POS_WIDTH-1:0]   r_offset, n_offset;
    logic [POS_WIDTH-1:0]   r_start, n_start;
    logic [63:0]            r_acc, n_acc;
    logic                   r_ovf, n_ovf;
    logic [LENW-1:0]        r_len, n_len;
    logic [7:0]             r_prefix [KEYWORD_MAX_LEN];

    logic                   w_digit, w_letter, w_space, w_alnum;
    logic [3:0]             w_digit_val;
    logic [67:0]            w_sum;
    logic [POS_WIDTH-1:0]   w_p1;
    logic [63:0]            w_p_ext, w_p1_ext, w_s_ext;
    logic [31:0]            w_p, w_pn, w_s;
    logic                   w_rescan, w_eof;
    logic [4:0]             w_ident_kind;
    logic                   w_a_valid, w_b_valid;
    t_token                 w_a, w_b;
    logic                   w_pfx_we;
    logic [IDXW-1:0]        w_pfx_idx;

    assign w_digit     = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign w_letter    = ((i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_Z)) ||
                         ((i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_Z));
    assign w_space     = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign w_alnum     = w_digit || w_letter;
    assign w_digit_val = 4'(i_char - CH_ZERO);

    // acc * 10 + d as two shifted adds; any carry past bit 63 is overflow.
    assign w_sum = 68'({r_acc, 3'b000}) + 68'({r_acc, 1'b0}) + 68'(w_digit_val);

    assign w_p1     = r_offset + 1'b1;
    assign w_p_ext  = 64'(r_offset);
    assign w_p1_ext = 64'(w_p1);
    assign w_s_ext  = 64'(r_start);
    assign w_p      = w_p_ext[31:0];
    assign w_pn     = w_p1_ext[31:0];
    assign w_s      = w_s_ext[31:0];

    // The byte is scanned as if idle when it ends the token in progress.
    always_comb begin
        case (r_mode)
            MODE_STR:   w_rescan = (i_char == CH_NUL);
            MODE_INT:   w_rescan = !w_digit;
            MODE_IDENT: w_rescan = !w_alnum;
            default:    w_rescan = 1'b1;
        endcase
    end
    assign w_eof = w_rescan && (i_char == CH_NUL);

    always_comb begin
        w_ident_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            logic hit;
            hit = (r_len == LENW'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_TXT; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    hit = hit && (r_prefix[i] ==
                          KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]);
                end
            end
            if (hit) begin
                w_ident_kind = 5'(int'(KIND_ELSE) + k);
            end
        end
    end

    // Result for the token that this byte ends.
    always_comb begin
        w_a_valid     = 1'b0;
        w_a           = '0;
        w_a.start_pos = w_s;
        w_a.end_pos   = w_p;
        case (r_mode)
            MODE_STR: begin
                w_a.kind = KIND_STRING;
                if (i_char == CH_QUOTE) begin
                    w_a_valid   = 1'b1;
                    w_a.end_pos = w_pn;
                end else if (i_char == CH_LF) begin
                    w_a_valid   = 1'b1;
                    w_a.end_pos = w_pn;
                    w_a.diag    = DIAG_UNENDED;
                end else if (i_char == CH_NUL) begin
                    w_a_valid   = 1'b1;
                    w_a.diag    = DIAG_UNENDED;
                end
            end
            MODE_INT: begin
                w_a.kind  = KIND_INT;
                w_a_valid = !w_digit;
                w_a.value = r_ovf ? 64'd0 : r_acc;
                w_a.diag  = r_ovf ? DIAG_OVERFLOW : DIAG_NONE;
            end
            MODE_IDENT: begin
                w_a.kind  = w_ident_kind;
                w_a_valid = !w_alnum;
            end
            default: begin
                w_a_valid = 1'b0;
            end
        endcase
    end

    // Result for the byte itself when scanned as if idle.
    always_comb begin
        w_b_valid     = w_rescan;
        w_b           = '0;
        w_b.start_pos = w_p;
        w_b.end_pos   = w_pn;
        w_b.last      = 1'b1;
        case (i_char)
            CH_NUL:    w_b.kind = KIND_EOF;
            CH_PLUS:   w_b.kind = KIND_PLUS;
            CH_SEMI:   w_b.kind = KIND_SEMI;
            CH_LBRACE: w_b.kind = KIND_LBRACE;
            CH_RBRACE: w_b.kind = KIND_RBRACE;
            CH_LPAREN: w_b.kind = KIND_LPAREN;
            CH_RPAREN: w_b.kind = KIND_RPAREN;
            CH_EQ:     w_b.kind = KIND_ASSIGN;
            CH_QUOTE:  w_b_valid = 1'b0;
            default: begin
                if (w_space || w_alnum) begin
                    w_b_valid = 1'b0;
                end else begin
                    w_b.kind = KIND_INVALID;
                    w_b.diag = DIAG_BAD_CHAR;
                    w_b.bad  = i_char;
                end
            end
        endcase
    end

    always_comb begin
        o_push.valid0    = i_fire && (w_a_valid || w_b_valid);
        o_push.valid1    = i_fire && w_a_valid && w_b_valid;
        o_push.tok0      = w_a_valid ? w_a : w_b;
        o_push.tok0.last = !(w_a_valid && w_b_valid);
        o_push.tok1      = w_b;
    end

    // Next state.
    always_comb begin
        n_mode    = r_mode;
        n_offset  = r_offset;
        n_start   = r_start;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_len     = r_len;
        w_pfx_we  = 1'b0;
        w_pfx_idx = r_len[IDXW-1:0];
        if (i_fire) begin
            case (r_mode)
                MODE_STR: begin
                    if ((i_char == CH_QUOTE) || (i_char == CH_LF)) begin
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_INT: begin
                    if (w_digit && !r_ovf) begin
                        if (|w_sum[67:64]) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_sum[63:0];
                        end
                    end
                end
                MODE_IDENT: begin
                    if (w_alnum) begin
                        w_pfx_we = (r_len < LENW'(KEYWORD_MAX_LEN));
                        if (r_len <= LENW'(KEYWORD_MAX_LEN)) begin
                            n_len = r_len + 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
            if (w_rescan) begin
                n_mode = MODE_IDLE;
                if (i_char == CH_QUOTE) begin
                    n_mode  = MODE_STR;
                    n_start = r_offset;
                end else if (w_digit) begin
                    n_mode  = MODE_INT;
                    n_start = r_offset;
                    n_acc   = 64'(w_digit_val);
                    n_ovf   = 1'b0;
                end else if (w_letter) begin
                    n_mode    = MODE_IDENT;
                    n_start   = r_offset;
                    n_len     = LENW'(1);
                    w_pfx_we  = 1'b1;
                    w_pfx_idx = '0;
                end
            end
            if (w_eof) begin
                n_mode   = MODE_IDLE;
                n_offset = '0;
                n_start  = '0;
                n_acc    = '0;
                n_ovf    = 1'b0;
                n_len    = '0;
            end else begin
                n_offset = w_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_offset <= '0;
            r_start  <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_len    <= '0;
        end else begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pfx_we) begin
            r_prefix[w_pfx_idx] <= i_char;
        end
    end

    `STS_ASSERT_NEXT(a_eof_restarts, i_clk, i_rst_n, i_fire && (i_char == CH_NUL), (r_offset == '0) && (r_mode == MODE_IDLE), "end of input did not restart the scan")
    `STS_ASSERT_NEXT(a_offset_steps, i_clk, i_rst_n, i_fire && (i_char != CH_NUL), r_offset == POS_WIDTH'($past(r_offset) + 1'b1), "byte offset did not advance by one")
    `STS_ASSERT_SAME(a_pair_order, i_clk, i_rst_n, o_push.valid1, o_push.valid0 && !o_push.tok0.last && o_push.tok1.last, "two results with wrong last marks")
    `STS_ASSERT_SAME(a_word_len_sat, i_clk, i_rst_n, 1'b1, r_len <= LENW'(KEYWORD_MAX_LEN + 1), "word length past saturation")

endmodule

`default_nettype wire

### rtl/sts_queue.sv
`default_nettype none
`include "source_token_scanner_defines.svh"

module sts_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sts_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_room,
    output logic                o_valid,
    output sts_pkg::t_token     o_head
);
    import sts_pkg::*;

    localparam int PTRW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_token             r_slot [QUEUE_DEPTH];
    logic [PTRW-1:0]    r_wptr, n_wptr;
    logic [PTRW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]    r_count, n_count;
    logic [PTRW-1:0]    w_wptr1;
    logic [CNTW:0]      w_need, w_have;

    assign w_wptr1 = PTRW'(r_wptr + 1'b1);
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rptr];

    // Room for a full pair, counting the beat that leaves this cycle.
    assign w_need = (CNTW+1)'(r_count) + (CNTW+1)'(2);
    assign w_have = (CNTW+1)'(QUEUE_DEPTH) + (CNTW+1)'(i_pop && o_valid);
    assign o_room = (w_need <= w_have);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push.valid1) begin
            n_wptr = PTRW'(r_wptr + 2'd2);
        end else if (i_push.valid0) begin
            n_wptr = w_wptr1;
        end
        if (i_pop && o_valid) begin
            n_rptr = PTRW'(r_rptr + 1'b1);
        end
        n_count = CNTW'(r_count + CNTW'(i_push.valid0) + CNTW'(i_push.valid1)
                        - CNTW'(i_pop && o_valid));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_slot[r_wptr] <= i_push.tok0;
        end
        if (i_push.valid1) begin
            r_slot[w_wptr1] <= i_push.tok1;
        end
    end

    `STS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(QUEUE_DEPTH), "result queue count past depth")
    `STS_ASSERT_SAME(a_pair_in_order, i_clk, i_rst_n, i_push.valid1, i_push.valid0, "second result pushed without the first")
    `STS_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, i_push.valid0, o_valid, "pushed result not visible")

endmodule

`default_nettype wire

### rtl/source_token_scanner.sv
// Byte-serial source scanner.
// Input channel: one source byte per beat on i_char_in (i_in_valid/o_in_ready).
// A zero byte ends the text: it yields an end token and offsets restart at 0.
// Output channel: one token per beat (o_out_valid/i_out_ready) with kind,
// start and end offsets, integer value, diagnostic, bad byte and a flag
// that marks the last token caused by a given byte (a byte can end the
// token in progress and start or be a token itself, so it gives 0 to 2).
// A byte is held in the input register; once the queue has room, its tokens
// are written into a four-entry result queue, which offers them on the output.
// Throughput: one byte per cycle while the receiver keeps up. A byte leaves
// the input register only when the queue has room for two tokens, so
// sustained rate is set by the output port's one token per cycle.
// When the receiver stalls, the queue fills and the input backs up; the
// held output beat stays stable. Reset (synchronous, active low) empties
// the queue and returns the scanner to idle at offset 0.
`default_nettype none

module source_token_scanner #(
    parameter int POS_WIDTH       = 32,
    parameter int KEYWORD_MAX_LEN = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_token_kind,
    output logic [31:0]      o_start_pos,
    output logic [31:0]      o_end_pos,
    output logic [63:0]      o_int_value,
    output logic [1:0]       o_diag_code,
    output logic [7:0]       o_bad_char,
    output logic             o_last_result
);
    import sts_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       w_room;
    logic       w_fire;
    t_push      w_push;
    t_token     w_head;

    assign w_fire     = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_char_in;
        end
    end

    sts_core #(
        .POS_WIDTH       (POS_WIDTH),
        .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_char  (r_in_char),
        .o_push  (w_push)
    );

    sts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_out_ready),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_head  (w_head)
    );

    assign o_token_kind  = w_head.kind;
    assign o_start_pos   = w_head.start_pos;
    assign o_end_pos     = w_head.end_pos;
    assign o_int_value   = w_head.value;
    assign o_diag_code   = w_head.diag;
    assign o_bad_char    = w_head.bad;
    assign o_last_result = w_head.last;

endmodule

`default_nettype wire

### tb/source_token_scanner_tb.sv
module source_token_scanner_tb;

    import sts_pkg::*;

    localparam int WORD_PREFIX_LEN = 5;
    localparam int ITEM_TARGET     = 1150;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 6;

    typedef enum int {
        PACE_STEADY,
        PACE_FULL,
        PACE_SPARSE
    } t_pace;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_char_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [4:0]  o_token_kind;
    logic [31:0] o_start_pos;
    logic [31:0] o_end_pos;
    logic [63:0] o_int_value;
    logic [1:0]  o_diag_code;
    logic [7:0]  o_bad_char;
    logic        o_last_result;

    source_token_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_token_kind  (o_token_kind),
        .o_start_pos   (o_start_pos),
        .o_end_pos     (o_end_pos),
        .o_int_value   (o_int_value),
        .o_diag_code   (o_diag_code),
        .o_bad_char    (o_bad_char),
        .o_last_result (o_last_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Keyword order follows the kind numbering: else is KIND_ELSE, trim is KIND_ELSE + 4.
    string keyword_text[5] = '{"else", "if", "my", "print", "trim"};

    // Shadow scanner state.
    t_scan_mode  lex_mode;
    logic [31:0] lex_offset;
    logic [31:0] lex_start;
    logic [63:0] lex_acc;
    logic        lex_ovf;
    logic [7:0]  lex_prefix[WORD_PREFIX_LEN];
    int          lex_len;

    t_token token_queue[$];

    t_pace sender_pace;
    t_pace sink_pace;
    int    bytes_sent;
    int    tokens_seen;
    int    error_count;
    int    cycle_count;

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void add_token(input logic [4:0] kind, input logic [31:0] s,
                                      input logic [31:0] e, input logic [63:0] val,
                                      input logic [1:0] diag, input logic [7:0] bad);
        t_token t;
        t.kind      = kind;
        t.start_pos = s;
        t.end_pos   = e;
        t.value     = val;
        t.diag      = diag;
        t.bad       = bad;
        t.last      = 1'b0;
        token_queue.insert(token_queue.size(), t);
    endfunction

    function automatic logic [4:0] word_kind();
        bit same;
        for (int k = 0; k < 5; k++) begin
            if (lex_len == keyword_text[k].len()) begin
                same = 1'b1;
                for (int i = 0; i < lex_len; i++) begin
                    if (lex_prefix[i] != keyword_text[k][i])
                        same = 1'b0;
                end
                if (same)
                    return KIND_ELSE + 5'(k);
            end
        end
        return KIND_IDENT;
    endfunction

    // Scans one byte from the idle state; returns 1 when the byte ends the text.
    function automatic bit lex_idle_byte(logic [7:0] c, logic [31:0] p);
        logic [31:0] e;
        e = p + 32'd1;
        case (c)
            CH_NUL: begin
                add_token(KIND_EOF, p, e, '0, DIAG_NONE, '0);
                return 1'b1;
            end
            CH_PLUS:   add_token(KIND_PLUS, p, e, '0, DIAG_NONE, '0);
            CH_SEMI:   add_token(KIND_SEMI, p, e, '0, DIAG_NONE, '0);
            CH_LBRACE: add_token(KIND_LBRACE, p, e, '0, DIAG_NONE, '0);
            CH_RBRACE: add_token(KIND_RBRACE, p, e, '0, DIAG_NONE, '0);
            CH_LPAREN: add_token(KIND_LPAREN, p, e, '0, DIAG_NONE, '0);
            CH_RPAREN: add_token(KIND_RPAREN, p, e, '0, DIAG_NONE, '0);
            CH_EQ:     add_token(KIND_ASSIGN, p, e, '0, DIAG_NONE, '0);
            CH_QUOTE: begin
                lex_mode  = MODE_STR;
                lex_start = p;
            end
            default: begin
                if (is_digit(c)) begin
                    lex_mode  = MODE_INT;
                    lex_start = p;
                    lex_acc   = 64'(c - CH_ZERO);
                    lex_ovf   = 1'b0;
                end else if (is_letter(c)) begin
                    lex_mode      = MODE_IDENT;
                    lex_start     = p;
                    lex_prefix[0] = c;
                    lex_len       = 1;
                end else if (!is_blank(c)) begin
                    add_token(KIND_INVALID, p, e, '0, DIAG_BAD_CHAR, c);
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        logic [31:0] p;
        logic [63:0] d;
        bit          rescan;
        bit          eof;
        int          n_before;
        p        = lex_offset;
        rescan   = 1'b0;
        eof      = 1'b0;
        n_before = token_queue.size();
        case (lex_mode)
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    add_token(KIND_STRING, lex_start, p + 32'd1, '0, DIAG_NONE, '0);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_LF) begin
                    add_token(KIND_STRING, lex_start, p + 32'd1, '0, DIAG_UNENDED, '0);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    add_token(KIND_STRING, lex_start, p, '0, DIAG_UNENDED, '0);
                    lex_mode = MODE_IDLE;
                    rescan   = 1'b1;
                end
            end
            MODE_INT: begin
                if (is_digit(c)) begin
                    d = 64'(c - CH_ZERO);
                    if (!lex_ovf) begin
                        if (lex_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                            lex_ovf = 1'b1;
                        else
                            lex_acc = lex_acc * 64'd10 + d;
                    end
                end else begin
                    if (lex_ovf)
                        add_token(KIND_INT, lex_start, p, '0, DIAG_OVERFLOW, '0);
                    else
                        add_token(KIND_INT, lex_start, p, lex_acc, DIAG_NONE, '0);
                    lex_mode = MODE_IDLE;
                    rescan   = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    if (lex_len < WORD_PREFIX_LEN)
                        lex_prefix[lex_len] = c;
                    if (lex_len <= WORD_PREFIX_LEN)
                        lex_len++;
                end else begin
                    add_token(word_kind(), lex_start, p, '0, DIAG_NONE, '0);
                    lex_mode = MODE_IDLE;
                    rescan   = 1'b1;
                end
            end
            default: rescan = 1'b1;
        endcase
        if (rescan)
            eof = lex_idle_byte(c, p);
        if (eof) begin
            lex_mode   = MODE_IDLE;
            lex_offset = '0;
            lex_start  = '0;
            lex_acc    = '0;
            lex_ovf    = 1'b0;
            lex_len    = 0;
        end else begin
            lex_offset = p + 32'd1;
        end
        if (token_queue.size() > n_before)
            token_queue[token_queue.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_wait(t_pace pace);
        case (pace)
            PACE_FULL:   return $urandom_range(0, 17);
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
            default:     return 0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = pick_wait(sender_pace);
        repeat (gap) @(negedge i_clk);
        i_char_in  = c;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(c);
        bytes_sent++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic wait_drain();
        while (token_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: token %0d %s expected 0x%0h actual 0x%0h",
                     $time, tokens_seen, what, want, got);
            error_count++;
        end
    endtask

    function automatic logic [7:0] random_word_char(bit allow_digit);
        int    pick;
        string starts;
        starts = "eipmt";
        pick   = $urandom_range(0, allow_digit ? 3 : 2);
        case (pick)
            0:       return 8'(starts[$urandom_range(0, starts.len() - 1)]);
            1:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            2:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            default: return CH_ZERO + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // Result side: random stalls, then one beat compared with the oldest prediction.
    initial begin : token_sink
        int     stall;
        t_token want;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_wait(sink_pace);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tokens_seen++;
            if (token_queue.size() == 0) begin
                $display("%0t: token %0d arrived with none expected, kind %0d start %0d",
                         $time, tokens_seen, o_token_kind, o_start_pos);
                error_count++;
            end else begin
                want = token_queue.pop_front();
                check_field("kind", 64'(want.kind), 64'(o_token_kind));
                check_field("start_pos", 64'(want.start_pos), 64'(o_start_pos));
                check_field("end_pos", 64'(want.end_pos), 64'(o_end_pos));
                check_field("int_value", want.value, o_int_value);
                check_field("diag_code", 64'(want.diag), 64'(o_diag_code));
                check_field("bad_char", 64'(want.bad), 64'(o_bad_char));
                check_field("last_result", 64'(want.last), 64'(o_last_result));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d tokens outstanding", $time, token_queue.size());
            $display("source_token_scanner verification failed");
            $finish;
        end
    end

    task automatic test_punctuation();
        send_text("+;{}()=");
    endtask

    // A keyword and an integer, each ended by the byte that follows it.
    task automatic test_token_boundaries();
        send_text("else=12;");
    endtask

    task automatic test_blank_and_invalid();
        send_text(" \n");
        send_byte(8'hFF);
        send_text("\t");
    endtask

    // Starts like a keyword but runs past the saved prefix.
    task automatic test_long_identifier();
        send_text("printer ");
    endtask

    task automatic test_string_endings();
        send_text("\"q\n\"a");
        send_byte(CH_NUL);
    endtask

    // The text after the end token must count offsets from zero again.
    task automatic test_end_of_input();
        send_text(";");
        send_byte(CH_NUL);
        send_text("+");
    endtask

    task automatic test_random_text();
        int         pick;
        int         len;
        int         frag_left;
        int         next_pause;
        logic [7:0] c;
        string      punct_chars;
        string      odd_chars;
        punct_chars = "+;{}()=";
        odd_chars   = "!#$%&'*,-./:<>?@[\\]^_|~";
        frag_left   = 0;
        next_pause  = 250;
        while (bytes_sent < ITEM_TARGET) begin
            if (frag_left == 0) begin
                sender_pace = t_pace'($urandom_range(0, 2));
                sink_pace   = t_pace'($urandom_range(0, 2));
                frag_left   = $urandom_range(10, 40);
            end
            frag_left--;
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_text(keyword_text[$urandom_range(0, 4)]);
            end else if (pick < 30) begin
                len = $urandom_range(1, 9);
                send_byte(random_word_char(1'b0));
                for (int i = 1; i < len; i++)
                    send_byte(random_word_char(1'b1));
            end else if (pick < 45) begin
                case ($urandom_range(0, 5))
                    0: begin
                        // Around the 64-bit limit: a last digit above 5 overflows.
                        send_text("1844674407370955161");
                        send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    1: begin
                        len = $urandom_range(20, 24);
                        for (int i = 0; i < len; i++)
                            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    default: begin
                        len = $urandom_range(1, 12);
                        for (int i = 0; i < len; i++)
                            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                endcase
            end else if (pick < 55) begin
                send_byte(CH_QUOTE);
                len = $urandom_range(0, 8);
                for (int i = 0; i < len; i++) begin
                    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_LF);
                    send_byte(c);
                end
                len = $urandom_range(0, 9);
                if (len < 7)
                    send_byte(CH_QUOTE);
                else if (len < 9)
                    send_byte(CH_LF);
                else
                    send_byte(CH_NUL);
            end else if (pick < 73) begin
                send_byte(8'(punct_chars[$urandom_range(0, punct_chars.len() - 1)]));
            end else if (pick < 85) begin
                // Space, or one of the control bytes from tab through carriage return.
                c = ($urandom_range(0, 5) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
                send_byte(c);
            end else if (pick < 90) begin
                case ($urandom_range(0, 3))
                    0:       c = 8'($urandom_range(127, 255));
                    1:       c = 8'($urandom_range(1, 8));
                    2:       c = 8'($urandom_range(14, 31));
                    default: c = 8'(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
                endcase
                send_byte(c);
            end else if (pick < 93) begin
                send_byte(CH_NUL);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
            if (bytes_sent >= next_pause) begin
                wait_drain();
                next_pause += 300;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_in   = '0;
        sender_pace = PACE_STEADY;
        sink_pace   = PACE_STEADY;
        bytes_sent  = 0;
        tokens_seen = 0;
        error_count = 0;
        cycle_count = 0;
        lex_mode    = MODE_IDLE;
        lex_offset  = '0;
        lex_start   = '0;
        lex_acc     = '0;
        lex_ovf     = 1'b0;
        lex_len     = 0;
        for (int i = 0; i < WORD_PREFIX_LEN; i++)
            lex_prefix[i] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_punctuation();
        sender_pace = PACE_FULL;
        test_token_boundaries();
        sink_pace = PACE_FULL;
        test_blank_and_invalid();
        test_long_identifier();
        sender_pace = PACE_SPARSE;
        test_string_endings();
        test_end_of_input();
        wait_drain();
        test_random_text();

        sink_pace = PACE_STEADY;
        wait_drain();
        $display("Scanned %0d source bytes and checked %0d tokens under random stalls.",
                 bytes_sent, tokens_seen);
        $display("Text covered keywords, 64-bit integer limits, string endings and bad bytes.");
        if (error_count == 0) begin
            $display("source_token_scanner verification clean");
        end else begin
            $display("source_token_scanner verification failed");
        end
        $finish;
    end

endmodule
